FILE: hdl/wsd_pkg.sv
// Shared types, codes and helpers for the websocket frame deframer.
// Used by the front parser, the word queue, the result stage and the top level.
package wsd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_HEADER    = 3'd1;
   localparam logic [2:0] ERR_EXT_LEN   = 3'd2;
   localparam logic [2:0] ERR_KEY       = 3'd3;
   localparam logic [2:0] ERR_PAYLOAD   = 3'd4;

   // One queue entry: everything one input word produces.
   typedef struct packed {
      logic        has_pay;
      logic [7:0]  pay_byte;
      logic        has_done;
      logic [7:0]  hdr_byte;
      logic        masked;
      logic [63:0] length;
      logic        has_err;
      logic [2:0]  err;
   } entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic        fin;
      logic [2:0]  rsv_bits;
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] payload_length;
      logic [2:0]  error_code;
      logic        end_of_run;
   } result_type;

   function automatic logic has_two(input entry_type e);
      return e.has_pay && (e.has_done || e.has_err);
   endfunction

   // Build the first or the second result of an entry.
   function automatic result_type make_result(input entry_type e, input logic second);
      result_type r;
      logic       show_pay;
      logic       show_done;
      r         = '0;
      show_pay  = e.has_pay && !second;
      show_done = !show_pay && e.has_done;
      if (show_pay) begin
         r.kind         = KIND_PAYLOAD;
         r.payload_byte = e.pay_byte;
         r.end_of_run   = !(e.has_done || e.has_err);
      end else if (show_done) begin
         r.kind           = KIND_DONE;
         r.fin            = e.hdr_byte[7];
         r.rsv_bits       = e.hdr_byte[6:4];
         r.opcode         = e.hdr_byte[3:0];
         r.masked         = e.masked;
         r.payload_length = e.length;
         r.end_of_run     = 1'b1;
      end else begin
         r.kind       = KIND_ERROR;
         r.error_code = e.err;
         r.end_of_run = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: hdl/wsd_front.sv
// Front parser: accepts raw frame words, tracks header, length, key and payload
// progress, and pushes one queue entry per word that yields results. Uses wsd_pkg.
module wsd_front
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output logic        push,
   output entry_type   push_entry
);

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_KEY  = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic        mask_ff, mask_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  kidx_ff, kidx_in;
   logic [63:0] remain_ff, remain_in;

   logic        after_len;
   logic        start_pl;
   logic        done;
   logic        has_pay;
   logic [7:0]  pay_byte;
   logic [7:0]  key_byte;
   logic        has_err;
   logic [2:0]  err;

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      remain_in = remain_ff;
      after_len = 1'b0;
      start_pl  = 1'b0;
      done      = 1'b0;
      has_pay   = 1'b0;
      pay_byte  = '0;
      has_err   = 1'b0;
      err       = ERR_NONE;

      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      unique case (phase_ff)
         PH_HDR0: begin
            hdr_in   = data_byte;
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            mask_in = data_byte[7];
            if (data_byte[6:0] == LEN_EXT16 || data_byte[6:0] == LEN_EXT64) begin
               cnt_in   = (data_byte[6:0] == LEN_EXT16) ? 3'd6 : 3'd0;
               len_in   = '0;
               phase_in = PH_EXT;
            end else begin
               len_in    = {57'd0, data_byte[6:0]};
               after_len = 1'b1;
            end
         end
         PH_EXT: begin
            len_in = {len_ff[55:0], data_byte};
            if (cnt_ff == 3'd7) begin
               after_len = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            if (cnt_ff >= 3'd3) begin
               start_pl = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_PAY: begin
            has_pay   = 1'b1;
            pay_byte  = data_byte ^ (mask_ff ? key_byte : 8'd0);
            kidx_in   = kidx_ff + 2'd1;
            remain_in = remain_ff - 64'd1;
            if (remain_ff == 64'd1) begin
               phase_in = PH_SKIP;
               done     = 1'b1;
            end
         end
         default: begin
            // ignore trailing words
         end
      endcase

      if (after_len) begin
         if (mask_in) begin
            phase_in = PH_KEY;
            cnt_in   = 3'd0;
         end else begin
            start_pl = 1'b1;
         end
      end

      if (start_pl) begin
         remain_in = len_in;
         kidx_in   = 2'd0;
         if (len_in == 64'd0) begin
            phase_in = PH_SKIP;
            done     = 1'b1;
         end else begin
            phase_in = PH_PAY;
         end
      end

      if (last_byte) begin
         if (!done) begin
            unique case (phase_in)
               PH_HDR1: begin
                  has_err = 1'b1;
                  err     = ERR_HEADER;
               end
               PH_EXT: begin
                  has_err = 1'b1;
                  err     = ERR_EXT_LEN;
               end
               PH_KEY: begin
                  has_err = 1'b1;
                  err     = ERR_KEY;
               end
               PH_PAY: begin
                  has_err = 1'b1;
                  err     = ERR_PAYLOAD;
               end
               default: begin
                  has_err = 1'b0;
               end
            endcase
         end
         phase_in = PH_HDR0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hdr_ff    <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         key_ff    <= '0;
         kidx_ff   <= '0;
         remain_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hdr_ff    <= hdr_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
         remain_ff <= remain_in;
      end
   end

   assign push = accept && (has_pay || done || has_err);

   always_comb begin
      push_entry          = '0;
      push_entry.has_pay  = has_pay;
      push_entry.pay_byte = pay_byte;
      push_entry.has_done = done;
      push_entry.hdr_byte = hdr_in;
      push_entry.masked   = mask_in;
      push_entry.length   = len_in;
      push_entry.has_err  = has_err;
      push_entry.err      = err;
   end

endmodule

FILE: hdl/wsd_fifo.sv
// Short entry queue between the front parser and the result stage.
// Uses wsd_pkg for the entry type.
module wsd_fifo
   import wsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   entry_type     slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (cnt_ff == FULL_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/wsd_back.sv
// Result stage: drains queue entries and presents one result word per unstalled cycle
// in an output register, holding an entry that carries a second result. Uses wsd_pkg.
module wsd_back
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   logic       hold_valid_ff, hold_valid_in;
   entry_type  hold_ff, hold_in;
   logic       load;

   assign load = !valid_ff || !out_stall;

   always_comb begin
      valid_in      = valid_ff;
      res_in        = res_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      pop           = 1'b0;
      if (load) begin
         if (hold_valid_ff) begin
            res_in        = make_result(hold_ff, 1'b1);
            valid_in      = 1'b1;
            hold_valid_in = 1'b0;
         end else if (head_valid) begin
            pop      = 1'b1;
            res_in   = make_result(head_entry, 1'b0);
            valid_in = 1'b1;
            // keep the entry for its trailing result
            if (has_two(head_entry)) begin
               hold_in       = head_entry;
               hold_valid_in = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      hold_ff <= hold_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;

endmodule

FILE: hdl/websocket_frame_deframer.sv
// Streaming websocket frame deframer.
// The req channel carries one frame byte per word, with req_last_byte on the
// final byte of a buffer. The rsp channel returns payload bytes with the mask
// removed, a frame-complete word with the header fields, or an error word that
// names the part of the frame cut short; rsp_end_of_run marks the last word
// caused by one request word. Both channels accept a word at a clock edge with
// valid high and stall low.
// A request word's first result passes through a queue slot and then the output
// register before it shows on rsp.
// One request word per cycle is taken while each yields at most one result and
// rsp_stall stays low; a word with two results (payload plus complete or error)
// occupies the rsp register for both in turn. The entry queue (QUEUE_DEPTH
// entries) absorbs those bursts; req_stall rises only when the queue is full.
// Non-payload bytes yield no payload word, at most a complete or error word.
// A rsp_stall freezes the output register; the queue fills and then stalls req.
// Reset (synchronous) empties the queue and output and returns the parser to
// the first header byte of a new buffer.
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_fin,
   output logic [2:0]  rsp_rsv_bits,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_end_of_run
);

   logic       accept;
   logic       push;
   entry_type  push_entry;
   logic       q_full;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;
   result_type result;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   wsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   wsd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_result (result)
   );

   assign rsp_kind           = result.kind;
   assign rsp_payload_byte   = result.payload_byte;
   assign rsp_fin            = result.fin;
   assign rsp_rsv_bits       = result.rsv_bits;
   assign rsp_opcode         = result.opcode;
   assign rsp_masked         = result.masked;
   assign rsp_payload_length = result.payload_length;
   assign rsp_error_code     = result.error_code;
   assign rsp_end_of_run     = result.end_of_run;

endmodule
